@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks used in the slot router modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define KSR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true outside reset.
`define KSR_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/ksr_pkg.sv @@
// ----------------------------------------------------------------------------
// Key slot router package
// Sizes, codes and the control/status bundles shared by the router modules.
// ----------------------------------------------------------------------------
package ksr_pkg;

    // Slot space and node limits.
    localparam int SLOT_COUNT = 16384;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int MAX_NODES  = 64;
    localparam int NODE_W     = 6;
    localparam int CNT_W      = NODE_W + 1;
    localparam int ENTRY_W    = NODE_W + 1;
    localparam int BYTE_W     = 8;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // A map entry with its top bit set marks the slot as unmapped.
    localparam logic [ENTRY_W-1:0] ENTRY_UNMAPPED = {1'b1, {NODE_W{1'b0}}};
    localparam logic [CNT_W-1:0]   MAX_NODES_C    = CNT_W'(MAX_NODES);

    // Input item kinds.
    typedef enum logic [1:0] {
        FUNC_KEY   = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_MAP   = 2'd2
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_NODES = 2'd1,
        STAT_UNMAPPED = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;   // write one entry of the reset clearing pass
        logic byte_upd;   // fold the input key byte into the CRCs
        logic key_end;    // last key byte: start the map read, restart the key
        logic map_wr;     // write one slot map entry
        logic query;      // load the empty-key answer into the output register
        logic lookup;     // map data is back: load the key answer
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // clearing pass is at its final entry
        logic out_valid;  // output register holds a beat
    } t_dp_sts;

endpackage

@@ sv/ksr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ksr_ram #(
    parameter int   WIDTH  = 8,
    parameter int   DEPTH  = 256,
    localparam int  ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ksr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Key slot router controller
// Sequences the clearing pass, input acceptance and the map lookup cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_in_func,
    input  logic               i_in_last,
    input  logic               i_out_ready,
    input  ksr_pkg::t_dp_sts   i_sts,
    output logic               o_in_ready,
    output ksr_pkg::t_ctrl_cmd o_cmd
);
    import ksr_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_RUN    = 2'd1,
        S_LOOKUP = 2'd2
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   out_free;
    logic   accept;

    // Take a beat only when the output register is empty or drains this cycle.
    always_comb begin
        out_free   = !i_sts.out_valid || i_out_ready;
        o_in_ready = (r_state == S_RUN) && out_free;
        accept     = o_in_ready && i_in_valid;
    end

    // Decode the state and the accepted beat into datapath commands.
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_step = (r_state == S_CLEAR);
        o_cmd.lookup   = (r_state == S_LOOKUP);
        if (accept) begin
            unique case (i_in_func)
                FUNC_KEY: begin
                    o_cmd.byte_upd = 1'b1;
                    o_cmd.key_end  = i_in_last;
                end
                FUNC_QUERY: begin
                    o_cmd.query = 1'b1;
                end
                FUNC_MAP: begin
                    o_cmd.map_wr = 1'b1;
                end
                default: begin
                    // The unused kind is taken and dropped.
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.key_end) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_RUN;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // The lookup takes exactly the cycle after the last key byte.
    `KSR_ASSERT(a_lookup_follows, i_clk, i_rst_n, (o_cmd.key_end |=> o_cmd.lookup), "lookup did not follow key end")
    `KSR_ASSERT(a_lookup_one_cycle, i_clk, i_rst_n, (r_state == S_LOOKUP |=> r_state == S_RUN), "lookup state held too long")

endmodule

@@ sv/ksr_dp.sv @@
// ----------------------------------------------------------------------------
// Key slot router datapath
// CRC16 over the key and hash tag, slot map memory and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksr_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ksr_pkg::t_ctrl_cmd           i_cmd,
    input  logic                         i_cfg_we,
    input  logic [ksr_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic [ksr_pkg::BYTE_W-1:0]   i_key_byte,
    input  logic [ksr_pkg::SLOT_W-1:0]   i_map_slot,
    input  logic [ksr_pkg::NODE_W-1:0]   i_map_node,
    input  logic                         i_map_clear,
    input  logic                         i_out_ready,
    output ksr_pkg::t_dp_sts             o_sts,
    output ksr_pkg::t_status             o_out_status,
    output logic [ksr_pkg::SLOT_W-1:0]   o_out_slot,
    output logic [ksr_pkg::NODE_W-1:0]   o_out_node
);
    import ksr_pkg::*;

    localparam logic [15:0]       CRC_POLY    = 16'h1021;
    localparam logic [BYTE_W-1:0] OPEN_BRACE  = 8'h7B;
    localparam logic [BYTE_W-1:0] CLOSE_BRACE = 8'h7D;

    // Hash tag tracking.
    typedef enum logic [2:0] {
        PH_SEEK    = 3'd0,
        PH_OPEN    = 3'd1,
        PH_INTAG   = 3'd2,
        PH_TAGDONE = 3'd3,
        PH_EMPTY   = 3'd4
    } t_phase;

    // One byte of CRC16-XMODEM, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [15:0]       r_crc_whole;
    logic [15:0]       r_crc_tag;
    t_phase            r_phase;
    logic [15:0]       n_crc_whole;
    logic [15:0]       n_crc_tag;
    t_phase            n_phase;
    logic [15:0]       sel_crc;
    logic [SLOT_W-1:0] key_slot;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_node_count;
    logic [CNT_W-1:0]  nodes_used;
    logic [SLOT_W-1:0] r_clr_addr;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_status           lk_status;
    logic [NODE_W-1:0] lk_node;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic [NODE_W-1:0] r_out_node;

    // CRC and tag phase update for the incoming byte.
    always_comb begin
        n_crc_whole = crc_byte(r_crc_whole, i_key_byte);
        n_crc_tag   = r_crc_tag;
        n_phase     = r_phase;
        unique case (r_phase)
            PH_SEEK: begin
                if (i_key_byte == OPEN_BRACE) begin
                    n_phase = PH_OPEN;
                end
            end
            PH_OPEN, PH_INTAG: begin
                if (i_key_byte == CLOSE_BRACE) begin
                    n_phase = (r_phase == PH_OPEN) ? PH_EMPTY : PH_TAGDONE;
                end else begin
                    n_crc_tag = crc_byte(r_crc_tag, i_key_byte);
                    n_phase   = PH_INTAG;
                end
            end
            default: begin
                // Tag closed: only the whole-key CRC moves on.
            end
        endcase
        sel_crc  = (n_phase == PH_TAGDONE) ? n_crc_tag : n_crc_whole;
        key_slot = sel_crc[SLOT_W-1:0];
    end

    // Key state: cleared after each finished key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_whole <= '0;
            r_crc_tag   <= '0;
            r_phase     <= PH_SEEK;
        end else if (i_cmd.key_end) begin
            r_crc_whole <= '0;
            r_crc_tag   <= '0;
            r_phase     <= PH_SEEK;
        end else if (i_cmd.byte_upd) begin
            r_crc_whole <= n_crc_whole;
            r_crc_tag   <= n_crc_tag;
            r_phase     <= n_phase;
        end
    end

    // Slot of the finished key, held for the lookup cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_end) begin
            r_slot <= key_slot;
        end
    end

    // Node count register and the count in use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    assign nodes_used = (r_node_count > MAX_NODES_C) ? MAX_NODES_C : r_node_count;

    // Clearing pass address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + SLOT_W'(1);
        end
    end

    assign o_sts.clr_last = i_cmd.clr_step && (r_clr_addr == SLOT_W'(SLOT_COUNT - 1));

    // Map write port: clearing pass or a map write beat.
    always_comb begin
        ram_we    = i_cmd.clr_step || i_cmd.map_wr;
        ram_waddr = i_cmd.clr_step ? r_clr_addr : i_map_slot;
        if (i_cmd.clr_step || i_map_clear) begin
            ram_wdata = ENTRY_UNMAPPED;
        end else begin
            ram_wdata = {1'b0, i_map_node};
        end
    end

    ksr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.key_end),
        .i_raddr (key_slot),
        .o_rdata (ram_rdata)
    );

    // Resolve the map entry against the node count.
    always_comb begin
        lk_node = '0;
        if (nodes_used == '0) begin
            lk_status = STAT_NO_NODES;
        end else if (ram_rdata[NODE_W] || ({1'b0, ram_rdata[NODE_W-1:0]} >= nodes_used)) begin
            lk_status = STAT_UNMAPPED;
        end else begin
            lk_status = STAT_OK;
            lk_node   = ram_rdata[NODE_W-1:0];
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.lookup || i_cmd.query) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_out_status <= lk_status;
            r_out_slot   <= r_slot;
            r_out_node   <= lk_node;
        end else if (i_cmd.query) begin
            r_out_status <= (nodes_used == '0) ? STAT_NO_NODES : STAT_OK;
            r_out_slot   <= '0;
            r_out_node   <= '0;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_out_status    = r_out_status;
    assign o_out_slot      = r_out_slot;
    assign o_out_node      = r_out_node;

    // A lookup result must never overwrite a beat still waiting downstream.
    `KSR_NEVER(a_lookup_into_full, i_clk, i_rst_n, (i_cmd.lookup && r_out_valid), "lookup loaded a full output register")
    `KSR_ASSERT(a_key_restart, i_clk, i_rst_n, (i_cmd.key_end |=> (r_crc_whole == '0 && r_crc_tag == '0 && r_phase == PH_SEEK)), "key state not restarted")

endmodule

@@ sv/key_slot_router_top.sv @@
// ----------------------------------------------------------------------------
// Key slot router
// Hashes streamed keys to cluster slots and looks the slot up in a node map.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit first)                        tuser / tlast
// s_axis    in   key_byte, map_slot, map_node, map_clear      tuser func, tlast last_byte
// m_axis    out  slot_number, node_index                      tuser status
// cfg       in   i_cfg_wdata = node_count, written on i_cfg_we
//
// Key bytes, queries and map writes need no state of their own; a last key byte leads
// to the lookup state, which resolves the registered slot map read.
// After reset all 16384 slot map entries are swept to unmapped, one entry per cycle;
// no input beat is taken during the sweep.
// An input beat is taken while a result waits only if that result drains in
// the same cycle; the output register holds one result.
// ----------------------------------------------------------------------------
module key_slot_router_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] key_byte, [21:8] map_slot, [27:22] map_node, [28] map_clear
    input  logic [ksr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [1:0]                        s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [13:0] slot_number, [19:14] node_index
    output logic [ksr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [1:0]                        m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [ksr_pkg::CNT_W-1:0]         i_cfg_wdata
);
    import ksr_pkg::*;

    localparam int MAP_SLOT_LO = BYTE_W;
    localparam int MAP_NODE_LO = MAP_SLOT_LO + SLOT_W;
    localparam int MAP_CLR_BIT = MAP_NODE_LO + NODE_W;
    localparam int OUT_PAD_W   = OUT_DATA_W - SLOT_W - NODE_W;

    t_ctrl_cmd         cmd;
    t_dp_sts           sts;
    t_status           out_status;
    logic [SLOT_W-1:0] out_slot;
    logic [NODE_W-1:0] out_node;

    // Controller.
    ksr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_func   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    // Datapath.
    ksr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_key_byte   (s_axis_tdata[BYTE_W-1:0]),
        .i_map_slot   (s_axis_tdata[MAP_NODE_LO-1:MAP_SLOT_LO]),
        .i_map_node   (s_axis_tdata[MAP_CLR_BIT-1:MAP_NODE_LO]),
        .i_map_clear  (s_axis_tdata[MAP_CLR_BIT]),
        .i_out_ready  (m_axis_tready),
        .o_sts        (sts),
        .o_out_status (out_status),
        .o_out_slot   (out_slot),
        .o_out_node   (out_node)
    );

    // Result beat packing.
    assign m_axis_tvalid = sts.out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_node, out_slot};
    assign m_axis_tuser  = out_status;

endmodule
